// File: rtl/core/isc_pkg.sv
// Shared types and codes for the image/screen coordinate mapper.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package isc_pkg;

    typedef enum logic [2:0] {
        MODE_IMG2SCR = 3'd0,
        MODE_SCR2IMG = 3'd1,
        MODE_SCR2VIR = 3'd2,
        MODE_VIR2SCR = 3'd3,
        MODE_IMG2VIR = 3'd4,
        MODE_VIR2IMG = 3'd5
    } t_mode;

    typedef enum logic [2:0] {
        CFG_PLACE_X  = 3'd0,
        CFG_PLACE_Y  = 3'd1,
        CFG_FIRST_X  = 3'd2,
        CFG_FIRST_Y  = 3'd3,
        CFG_COMPRESS = 3'd4,
        CFG_ZOOM     = 3'd5,
        CFG_CENTER_X = 3'd6,
        CFG_CENTER_Y = 3'd7
    } t_cfg_idx;

    localparam int ZOOM_BITS = 8;

    typedef struct packed {
        logic vld;
        logic neg;
        logic bad;
    } t_ctl;

endpackage

// File: rtl/core/isc_prep.sv
// Numerator and denominator pipeline for one axis: five register stages that
// build the signed rational numerator, then split it into sign and magnitude. Uses isc_pkg.
`timescale 1ns / 1ps

module isc_prep import isc_pkg::*; #(
    parameter int COORD_BITS  = 16,
    parameter int FACTOR_BITS = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_en,
    input  logic                                   i_valid,
    input  logic [2:0]                             i_mode,
    input  logic signed [COORD_BITS-1:0]           i_k,
    input  logic signed [COORD_BITS-1:0]           i_place,
    input  logic signed [COORD_BITS-1:0]           i_first,
    input  logic signed [COORD_BITS-1:0]           i_ctr,
    input  logic [FACTOR_BITS-1:0]                 i_c,
    input  logic [ZOOM_BITS-1:0]                   i_z,
    output t_ctl                                   o_ctl,
    output logic [FACTOR_BITS+COORD_BITS+12:0]     o_mag,
    output logic [((FACTOR_BITS > ZOOM_BITS) ? FACTOR_BITS : ZOOM_BITS)-1:0] o_den
);

    localparam int AW = COORD_BITS + 1;
    localparam int PW = FACTOR_BITS + COORD_BITS + 3;
    localparam int NW = PW + 10;
    localparam int DW = (FACTOR_BITS > ZOOM_BITS) ? FACTOR_BITS : ZOOM_BITS;
    localparam logic signed [AW-1:0] ONE = AW'(1);

    logic signed [AW-1:0]  r1_a, r1_b, r1_e, n1_a, n1_b, n1_e;
    logic [FACTOR_BITS-1:0] r1_m1, r1_m3, n1_m1, n1_m3;
    logic [ZOOM_BITS-1:0]  r1_zz, r2_zz, n1_zz;
    logic [DW-1:0]         r1_den, r2_den, r3_den, r4_den, r5_den, n1_den;
    t_ctl                  r1_ctl, r2_ctl, r3_ctl, r4_ctl, r5_ctl, n1_ctl;
    logic signed [PW-2:0]  p1, p3;
    logic signed [PW-1:0]  r2_t, r2_u, r3_u, n2_t;
    logic signed [PW+8:0]  r3_v, n3_v;
    logic signed [NW-1:0]  r4_num, n4_num;
    logic [NW-1:0]         r5_mag, n5_mag;

    always_comb begin
        logic signed [AW-1:0] kk, pl, fi, ct;
        logic [FACTOR_BITS-1:0] cc;
        logic [ZOOM_BITS-1:0]   zq;
        kk = AW'(i_k);
        pl = AW'(i_place);
        fi = AW'(i_first);
        ct = AW'(i_ctr);
        cc = (i_c == '0) ? FACTOR_BITS'(1) : i_c;
        zq = (i_z == '0) ? ZOOM_BITS'(1) : i_z;
        n1_a   = '0;
        n1_b   = '0;
        n1_e   = '0;
        n1_m1  = '0;
        n1_m3  = '0;
        n1_zz  = ZOOM_BITS'(1);
        n1_den = DW'(1);
        n1_ctl = '{vld: i_valid, neg: 1'b0, bad: 1'b0};
        unique case (t_mode'(i_mode))
            MODE_IMG2SCR: begin
                n1_a = kk - fi; n1_b = pl - ct; n1_m1 = cc;
                n1_e = ONE; n1_m3 = cc; n1_zz = zq; n1_den = DW'(cc);
            end
            MODE_SCR2IMG: begin
                n1_a = fi; n1_b = ct - pl; n1_m1 = cc;
                n1_e = kk - ONE; n1_m3 = cc; n1_zz = zq; n1_den = DW'(zq);
            end
            MODE_SCR2VIR: begin
                n1_a = ct; n1_e = kk - ONE; n1_m3 = FACTOR_BITS'(1);
                n1_zz = zq; n1_den = DW'(zq);
            end
            MODE_VIR2SCR: begin
                n1_a = kk - ct; n1_e = ONE; n1_m3 = FACTOR_BITS'(1); n1_zz = zq;
            end
            MODE_IMG2VIR: begin
                n1_a = kk - fi; n1_b = pl; n1_m1 = cc; n1_den = DW'(cc);
            end
            MODE_VIR2IMG: begin
                n1_a = fi; n1_b = kk - pl; n1_m1 = cc;
            end
            default: begin
                n1_ctl.bad = 1'b1;
            end
        endcase
    end

    assign p1   = $signed({1'b0, r1_m1}) * r1_b;
    assign p3   = $signed({1'b0, r1_m3}) * r1_e;
    assign n2_t = PW'(r1_a) + PW'(p1);
    assign n3_v = $signed({1'b0, r2_zz}) * r2_t;
    assign n4_num = NW'(r3_v) + NW'(r3_u);
    assign n5_mag = r4_num[NW-1] ? NW'(-r4_num) : NW'(r4_num);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl <= '0;
            r2_ctl <= '0;
            r3_ctl <= '0;
            r4_ctl <= '0;
            r5_ctl <= '0;
        end else if (i_en) begin
            r1_ctl <= n1_ctl;
            r2_ctl <= r1_ctl;
            r3_ctl <= r2_ctl;
            r4_ctl <= r3_ctl;
            r5_ctl <= '{vld: r4_ctl.vld, neg: r4_num[NW-1], bad: r4_ctl.bad};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_a   <= n1_a;
            r1_b   <= n1_b;
            r1_e   <= n1_e;
            r1_m1  <= n1_m1;
            r1_m3  <= n1_m3;
            r1_zz  <= n1_zz;
            r1_den <= n1_den;
            r2_t   <= n2_t;
            r2_u   <= PW'(p3);
            r2_zz  <= r1_zz;
            r2_den <= r1_den;
            r3_v   <= n3_v;
            r3_u   <= r2_u;
            r3_den <= r2_den;
            r4_num <= n4_num;
            r4_den <= r3_den;
            r5_mag <= n5_mag;
            r5_den <= r4_den;
        end
    end

    assign o_ctl = r5_ctl;
    assign o_mag = r5_mag;
    assign o_den = r5_den;

endmodule

// File: rtl/core/isc_div.sv
// Pipelined restoring divider: one quotient bit per register stage.
// Carries the isc_pkg control word alongside the data.
`timescale 1ns / 1ps

module isc_div import isc_pkg::*; #(
    parameter int NW = 45,
    parameter int DW = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  t_ctl          i_ctl,
    input  logic [NW-1:0] i_mag,
    input  logic [DW-1:0] i_den,
    output t_ctl          o_ctl,
    output logic [NW-1:0] o_quo
);

    logic [DW-1:0] r_rem [NW];
    logic [NW-1:0] r_dq  [NW];
    logic [DW-1:0] r_den [NW];
    t_ctl          r_ctl [NW];

    genvar j;
    generate
        for (j = 0; j < NW; j++) begin : g_stage
            logic [DW-1:0] rem_in, den_in, n_rem;
            logic [NW-1:0] dq_in, n_dq;
            t_ctl          ctl_in;
            logic [DW:0]   trial, diff;

            if (j == 0) begin : g_first
                assign rem_in = '0;
                assign dq_in  = i_mag;
                assign den_in = i_den;
                assign ctl_in = i_ctl;
            end else begin : g_next
                assign rem_in = r_rem[j-1];
                assign dq_in  = r_dq[j-1];
                assign den_in = r_den[j-1];
                assign ctl_in = r_ctl[j-1];
            end

            assign trial = {rem_in, dq_in[NW-1]};
            assign diff  = trial - {1'b0, den_in};
            assign n_rem = diff[DW] ? trial[DW-1:0] : diff[DW-1:0];
            assign n_dq  = {dq_in[NW-2:0], ~diff[DW]};

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_ctl[j] <= '0;
                end else if (i_en) begin
                    r_ctl[j] <= ctl_in;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[j] <= n_rem;
                    r_dq[j]  <= n_dq;
                    r_den[j] <= den_in;
                end
            end
        end
    endgenerate

    assign o_ctl = r_ctl[NW-1];
    assign o_quo = r_dq[NW-1];

endmodule

// File: rtl/core/image_screen_coordinate_mapper_unit.sv
// Top level of the image/screen coordinate mapper: configuration registers,
// per-axis numerator pipelines and dividers, saturation and output register.
// Depends on isc_pkg, isc_prep and isc_div.
//
// Usage: configuration words arrive on i_cfg_we/i_cfg_index/i_cfg_data and are
// taken at once; the user must write them only while no coordinate is in
// flight, as the block itself does not enforce it. Coordinate words enter on the
// s_axis channel (tuser carries the mode) and leave on m_axis, one result word
// per input word, in order, with the clipped flag in tuser. The pipeline has
// five numerator stages, one divider stage per numerator bit, one output stage.
// Throughput is one word per cycle unless the receiver stalls. The whole
// pipeline advances as one; when the receiver holds tready low with a result
// waiting, every stage holds and s_axis_tready drops in the same cycle, so
// nothing is lost or repeated. Reset clears all valid bits and loads every
// configuration register with its documented reset value.
`timescale 1ns / 1ps

module image_screen_coordinate_mapper_unit import isc_pkg::*; #(
    parameter int COORD_BITS  = 16,
    parameter int FACTOR_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [2:0]               i_cfg_index,
    input  logic [((((COORD_BITS > 2*FACTOR_BITS) ? COORD_BITS : 2*FACTOR_BITS) > 8) ?
                  ((COORD_BITS > 2*FACTOR_BITS) ? COORD_BITS : 2*FACTOR_BITS) : 8)-1:0]
                                     i_cfg_data,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // Fields from bit 0: coord_x, coord_y.
    input  logic [((2*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    // Fields from bit 0: mode.
    input  logic [2:0]               s_axis_tuser,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // Fields from bit 0: result_x, result_y.
    output logic [((2*COORD_BITS+7)/8)*8-1:0] m_axis_tdata,
    // Fields from bit 0: clipped.
    output logic                     m_axis_tuser
);

    localparam int C  = COORD_BITS;
    localparam int F  = FACTOR_BITS;
    localparam int NW = F + C + 13;
    localparam int DW = (F > ZOOM_BITS) ? F : ZOOM_BITS;
    localparam int DBW = ((2*C+7)/8)*8;
    localparam logic signed [NW:0] SMAX = {{(NW-C+2){1'b0}}, {(C-1){1'b1}}};
    localparam logic signed [NW:0] SMIN = {{(NW-C+2){1'b1}}, {(C-1){1'b0}}};

    logic signed [C-1:0] r_place_x, r_place_y, r_first_x, r_first_y, r_ctr_x, r_ctr_y;
    logic [2*F-1:0]      r_cmp;
    logic [ZOOM_BITS-1:0] r_zoom;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_place_x <= C'(1);
            r_place_y <= C'(1);
            r_first_x <= C'(1);
            r_first_y <= C'(1);
            r_cmp     <= {F'(1), F'(1)};
            r_zoom    <= ZOOM_BITS'(1);
            r_ctr_x   <= C'(1);
            r_ctr_y   <= C'(1);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_PLACE_X:  r_place_x <= i_cfg_data[C-1:0];
                CFG_PLACE_Y:  r_place_y <= i_cfg_data[C-1:0];
                CFG_FIRST_X:  r_first_x <= i_cfg_data[C-1:0];
                CFG_FIRST_Y:  r_first_y <= i_cfg_data[C-1:0];
                CFG_COMPRESS: r_cmp     <= i_cfg_data[2*F-1:0];
                CFG_ZOOM:     r_zoom    <= i_cfg_data[ZOOM_BITS-1:0];
                CFG_CENTER_X: r_ctr_x   <= i_cfg_data[C-1:0];
                CFG_CENTER_Y: r_ctr_y   <= i_cfg_data[C-1:0];
                default: ;
            endcase
        end
    end

    logic          en;
    logic          r_vld, r_clip;
    logic [C-1:0]  r_rx, r_ry;
    t_ctl          px_ctl, py_ctl, dx_ctl, dy_ctl;
    logic [NW-1:0] px_mag, py_mag, qx, qy;
    logic [DW-1:0] px_den, py_den;

    assign en = !r_vld || m_axis_tready;

    isc_prep #(.COORD_BITS(C), .FACTOR_BITS(F)) u_prep_x (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(s_axis_tvalid), .i_mode(s_axis_tuser),
        .i_k(s_axis_tdata[C-1:0]), .i_place(r_place_x), .i_first(r_first_x),
        .i_ctr(r_ctr_x), .i_c(r_cmp[F-1:0]), .i_z(r_zoom),
        .o_ctl(px_ctl), .o_mag(px_mag), .o_den(px_den)
    );

    isc_prep #(.COORD_BITS(C), .FACTOR_BITS(F)) u_prep_y (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(s_axis_tvalid), .i_mode(s_axis_tuser),
        .i_k(s_axis_tdata[2*C-1:C]), .i_place(r_place_y), .i_first(r_first_y),
        .i_ctr(r_ctr_y), .i_c(r_cmp[2*F-1:F]), .i_z(r_zoom),
        .o_ctl(py_ctl), .o_mag(py_mag), .o_den(py_den)
    );

    isc_div #(.NW(NW), .DW(DW)) u_div_x (
        .i_clk, .i_rst_n, .i_en(en), .i_ctl(px_ctl), .i_mag(px_mag), .i_den(px_den),
        .o_ctl(dx_ctl), .o_quo(qx)
    );

    isc_div #(.NW(NW), .DW(DW)) u_div_y (
        .i_clk, .i_rst_n, .i_en(en), .i_ctl(py_ctl), .i_mag(py_mag), .i_den(py_den),
        .o_ctl(dy_ctl), .o_quo(qy)
    );

    logic signed [NW:0] sx, sy;
    logic [C-1:0]       n_rx, n_ry;
    logic               n_clip;

    assign sx = dx_ctl.neg ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
    assign sy = dy_ctl.neg ? -$signed({1'b0, qy}) : $signed({1'b0, qy});

    always_comb begin
        n_clip = 1'b0;
        priority if (sx > SMAX) begin
            n_rx = SMAX[C-1:0]; n_clip = 1'b1;
        end else if (sx < SMIN) begin
            n_rx = SMIN[C-1:0]; n_clip = 1'b1;
        end else begin
            n_rx = sx[C-1:0];
        end
        priority if (sy > SMAX) begin
            n_ry = SMAX[C-1:0]; n_clip = 1'b1;
        end else if (sy < SMIN) begin
            n_ry = SMIN[C-1:0]; n_clip = 1'b1;
        end else begin
            n_ry = sy[C-1:0];
        end
        if (dx_ctl.bad || dy_ctl.bad) begin
            n_rx = '0; n_ry = '0; n_clip = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (en) begin
            r_vld <= dx_ctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rx   <= n_rx;
            r_ry   <= n_ry;
            r_clip <= n_clip;
        end
    end

    assign s_axis_tready = en;
    assign m_axis_tvalid = r_vld;
    assign m_axis_tdata  = DBW'({r_ry, r_rx});
    assign m_axis_tuser  = r_clip;

endmodule
